>>> rtl/core/gtg_pkg.sv
package gtg_pkg;

   localparam int FRAC_BITS_DEF     = 12;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANG_Q             = 24;
   localparam int TAB_LEN           = 24;
   localparam int POS_W             = 18;
   localparam int HEAD_W            = 15;
   localparam int LIM_W             = 13;
   localparam int ANG_OUT_W         = 15;
   localparam int GAIN_W            = 16;
   localparam int CREG_W            = 14;
   // Offset needs one more bit than a position; growth over the stages adds two more.
   localparam int CX_W              = POS_W + 3;
   localparam int ACC_W             = 28;

   localparam logic signed [ACC_W-1:0] PI_Q24   = 28'sd52707179;
   localparam logic [29:0]             KINV_Q30 = 30'd652032874;

   localparam logic [1:0] ADDR_TURN_GAIN      = 2'd0;
   localparam logic [1:0] ADDR_ANGULAR_LIMIT  = 2'd1;
   localparam logic [1:0] ADDR_HEADING_CUTOFF = 2'd2;
   localparam logic [1:0] ADDR_STOP_DISTANCE  = 2'd3;

   localparam logic [GAIN_W-1:0] TURN_GAIN_RST      = 16'd2560;
   localparam logic [CREG_W-1:0] ANGULAR_LIMIT_RST  = 14'd11551;
   localparam logic [CREG_W-1:0] HEADING_CUTOFF_RST = 14'd3217;
   localparam logic [CREG_W-1:0] STOP_DISTANCE_RST  = 14'd410;

   typedef struct packed {
      logic [GAIN_W-1:0] turn_gain;
      logic [CREG_W-1:0] angular_limit;
      logic [CREG_W-1:0] heading_cutoff;
      logic [CREG_W-1:0] stop_distance;
   } cfg_type;

   function automatic logic signed [ACC_W-1:0] atan_q24(input int i);
      logic signed [ACC_W-1:0] t;
      case (i)
         0: t = 28'sd13176795;
         1: t = 28'sd7778716;
         2: t = 28'sd4110060;
         3: t = 28'sd2086331;
         4: t = 28'sd1047214;
         5: t = 28'sd524117;
         6: t = 28'sd262123;
         7: t = 28'sd131069;
         default: t = (i < TAB_LEN) ? ACC_W'(28'sd65536 >>> (i - 8)) : '0;
      endcase
      return t;
   endfunction

endpackage

>>> rtl/core/gtg_stream_if.sv
interface gtg_stream_if #(parameter int W = 1) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/gtg_csr.sv
module gtg_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output gtg_pkg::cfg_type      cfg
);
   gtg_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0] idx;

   // The low address bits do not take part in the decode.
   assign idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (idx)
            gtg_pkg::ADDR_TURN_GAIN:      cfg_in.turn_gain = csr_pwdata[15:0];
            gtg_pkg::ADDR_ANGULAR_LIMIT:  cfg_in.angular_limit = csr_pwdata[13:0];
            gtg_pkg::ADDR_HEADING_CUTOFF: cfg_in.heading_cutoff = csr_pwdata[13:0];
            gtg_pkg::ADDR_STOP_DISTANCE:  cfg_in.stop_distance = csr_pwdata[13:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         gtg_pkg::ADDR_TURN_GAIN:      csr_prdata = {16'd0, cfg_ff.turn_gain};
         gtg_pkg::ADDR_ANGULAR_LIMIT:  csr_prdata = {18'd0, cfg_ff.angular_limit};
         gtg_pkg::ADDR_HEADING_CUTOFF: csr_prdata = {18'd0, cfg_ff.heading_cutoff};
         gtg_pkg::ADDR_STOP_DISTANCE:  csr_prdata = {18'd0, cfg_ff.stop_distance};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gtg_pkg::TURN_GAIN_RST, gtg_pkg::ANGULAR_LIMIT_RST,
                     gtg_pkg::HEADING_CUTOFF_RST, gtg_pkg::STOP_DISTANCE_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

>>> rtl/core/gtg_cordic.sv
// Pipelined vectoring CORDIC: one register stage per micro-rotation.
// The enable advances every stage at once; valid bits travel alongside.
module gtg_cordic #(
   parameter int STAGES = gtg_pkg::CORDIC_STAGES_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic signed [gtg_pkg::CX_W-1:0]         in_x,
   input  logic signed [gtg_pkg::CX_W-1:0]         in_y,
   input  logic [SIDE_W-1:0]                       in_side,
   output logic                                    out_valid,
   output logic signed [gtg_pkg::CX_W-1:0]         out_x,
   output logic signed [gtg_pkg::ACC_W-1:0]        out_acc,
   output logic                                    out_zero,
   output logic [SIDE_W-1:0]                       out_side
);
   localparam int XW = gtg_pkg::CX_W;
   localparam int AW = gtg_pkg::ACC_W;

   logic signed [XW-1:0] x_ff [STAGES+1];
   logic signed [XW-1:0] y_ff [STAGES+1];
   logic signed [AW-1:0] a_ff [STAGES+1];
   logic                 z_ff [STAGES+1];
   logic [SIDE_W-1:0]    s_ff [STAGES+1];
   logic                 v_ff [STAGES+1];

   // Stage 0: fold the left half plane onto the right one.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0] <= (in_x == '0) && (in_y == '0);
         s_ff[0] <= in_side;
         if (in_x < 0) begin
            x_ff[0] <= -in_x;
            y_ff[0] <= -in_y;
            a_ff[0] <= (in_y >= 0) ? gtg_pkg::PI_Q24 : -gtg_pkg::PI_Q24;
         end else begin
            x_ff[0] <= in_x;
            y_ff[0] <= in_y;
            a_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic signed [AW-1:0] ATAN = gtg_pkg::atan_q24(i);
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            z_ff[i+1] <= z_ff[i];
            s_ff[i+1] <= s_ff[i];
            if (y_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] + ATAN;
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               a_ff[i+1] <= a_ff[i] - ATAN;
            end
         end
      end
   end

   assign out_valid = v_ff[STAGES];
   assign out_x     = x_ff[STAGES];
   assign out_acc   = a_ff[STAGES];
   assign out_zero  = z_ff[STAGES];
   assign out_side  = s_ff[STAGES];
endmodule

>>> rtl/core/gtg_post.sv
// Post-processing: scale distance, round bearing, wrap error, gain and clamps.
// Four register stages, all advanced by the shared enable.
module gtg_post #(
   parameter int FRAC_BITS = gtg_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [gtg_pkg::CX_W-1:0]      in_x,
   input  logic signed [gtg_pkg::ACC_W-1:0]     in_acc,
   input  logic                                 in_zero,
   input  logic signed [gtg_pkg::HEAD_W-1:0]    in_heading,
   input  logic [gtg_pkg::LIM_W-1:0]            in_limit,
   input  gtg_pkg::cfg_type                     cfg,
   output logic                                 out_valid,
   output logic [gtg_pkg::LIM_W-1:0]            out_linear,
   output logic signed [gtg_pkg::ANG_OUT_W-1:0] out_angular
);
   localparam int SH = gtg_pkg::ANG_Q - FRAC_BITS;
   localparam int EW = 20;
   localparam int DW = gtg_pkg::CX_W + 1;
   localparam logic signed [gtg_pkg::ACC_W-1:0] PI_F =
      (gtg_pkg::PI_Q24 + (gtg_pkg::ACC_W'(1) <<< (SH - 1))) >>> SH;

   // stage A: distance product, bearing round
   logic [gtg_pkg::CX_W+30-1:0]  prod_ff;
   logic signed [EW-1:0]         bear_ff;
   logic signed [gtg_pkg::HEAD_W-1:0] hd_a_ff;
   logic [gtg_pkg::LIM_W-1:0]    lim_a_ff;
   logic                         v_a_ff;

   logic signed [gtg_pkg::ACC_W-1:0] acc_r;
   assign acc_r = (in_acc + $signed(gtg_pkg::ACC_W'(1) <<< (SH - 1))) >>> SH;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= in_zero ? '0 :
                     (gtg_pkg::CX_W+30)'($unsigned(in_x)) * (gtg_pkg::CX_W+30)'(gtg_pkg::KINV_Q30);
         bear_ff  <= in_zero ? '0 : EW'(acc_r);
         hd_a_ff  <= in_heading;
         lim_a_ff <= in_limit;
      end
   end

   // stage B: distance round, wrapped error
   logic [DW-1:0]         dist_ff;
   logic signed [EW-1:0]  err_ff;
   logic [gtg_pkg::LIM_W-1:0] lim_b_ff;
   logic                  v_b_ff;
   logic signed [EW-1:0]  err_raw, err_w, hd_e, pi_e;
   logic [gtg_pkg::CX_W+30-1:0] prod_r;

   assign hd_e    = EW'(hd_a_ff);
   assign pi_e    = EW'(PI_F);
   assign err_raw = hd_e - bear_ff;
   assign prod_r  = prod_ff + ((gtg_pkg::CX_W+30)'(1) << 29);
   always_comb begin
      err_w = err_raw;
      if (err_raw > pi_e || err_raw < -pi_e) begin
         if (hd_e > bear_ff) err_w = err_raw - (pi_e <<< 1);
         else                err_w = err_raw + (pi_e <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff  <= DW'(prod_r >> 30);
         err_ff   <= err_w;
         lim_b_ff <= lim_a_ff;
      end
   end

   // stage C: gain product, linear speed
   logic signed [EW+17-1:0] p_ff;
   logic [gtg_pkg::LIM_W-1:0] lin_ff;
   logic                    near_ff;
   logic                    v_c_ff;
   logic [EW-1:0]           mag;
   logic [gtg_pkg::LIM_W-1:0] lin_c;

   assign mag = err_ff[EW-1] ? EW'(-err_ff) : EW'(err_ff);
   always_comb begin
      lin_c = (dist_ff > DW'(lim_b_ff)) ? lim_b_ff : gtg_pkg::LIM_W'(dist_ff);
      if (mag > EW'(cfg.heading_cutoff)) lin_c = '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= (EW+17)'(err_ff) * $signed({1'b0, cfg.turn_gain});
         lin_ff  <= lin_c;
         near_ff <= dist_ff < DW'(cfg.stop_distance);
      end
   end

   // stage D: round, clamp, negate
   logic signed [EW+17-1:0] p_sh, alim;
   logic signed [EW+17-1:0] p_cl;
   logic [gtg_pkg::LIM_W-1:0] lin_d_ff;
   logic signed [gtg_pkg::ANG_OUT_W-1:0] ang_d_ff;
   logic v_d_ff;

   assign p_sh = (p_ff + (EW+17)'(128)) >>> 8;
   assign alim = (EW+17)'(cfg.angular_limit);
   always_comb begin
      p_cl = p_sh;
      if (p_sh > alim) p_cl = alim;
      if (p_sh < -alim) p_cl = -alim;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lin_d_ff <= lin_ff;
         ang_d_ff <= near_ff ? '0 : gtg_pkg::ANG_OUT_W'(-p_cl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_a_ff <= 1'b0;
         v_b_ff <= 1'b0;
         v_c_ff <= 1'b0;
         v_d_ff <= 1'b0;
      end else if (en) begin
         v_a_ff <= in_valid;
         v_b_ff <= v_a_ff;
         v_c_ff <= v_b_ff;
         v_d_ff <= v_c_ff;
      end
   end

   assign out_valid   = v_d_ff;
   assign out_linear  = lin_d_ff;
   assign out_angular = ang_d_ff;
endmodule

>>> rtl/core/go_to_goal_velocity_top.sv
// Go-to-goal velocity controller.
// req channel: one transfer carries pos_x, pos_y, heading, goal_x, goal_y and
// speed_limit. rsp channel: one transfer per request with linear_speed and
// angular_rate. The csr port (APB style, pready always high) holds turn_gain,
// angular_limit, heading_cutoff and stop_distance at byte addresses 0, 4, 8, 12.
// Throughput is one item per cycle while the receiver does not stall: the
// CORDIC vectoring pipeline has a fold stage and one stage per micro-rotation,
// followed by four post stages and the output register.
// The whole pipeline advances when the output register is empty or being
// taken; when the receiver stalls with a full output register, req_ready drops
// and every stage holds its item. Reset clears all valid bits and loads the
// register defaults; no clearing pass is needed.
module go_to_goal_velocity_top #(
   parameter int FRAC_BITS     = gtg_pkg::FRAC_BITS_DEF,
   parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   gtg_stream_if.sink  req,
   gtg_stream_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SIDE_W = gtg_pkg::HEAD_W + gtg_pkg::LIM_W;
   localparam int XW = gtg_pkg::CX_W;

   gtg_pkg::cfg_type cfg;
   logic en;
   logic c_valid, c_zero, p_valid;
   logic signed [XW-1:0] c_x, dx, dy;
   logic signed [gtg_pkg::ACC_W-1:0] c_acc;
   logic [SIDE_W-1:0] c_side;
   logic [gtg_pkg::LIM_W-1:0] lin;
   logic signed [gtg_pkg::ANG_OUT_W-1:0] ang;

   logic signed [gtg_pkg::POS_W-1:0] pos_x, pos_y, goal_x, goal_y;
   assign {pos_x, pos_y} = req.data[gtg_pkg::LIM_W+gtg_pkg::HEAD_W+2*gtg_pkg::POS_W +:
                                    2*gtg_pkg::POS_W];
   assign {goal_x, goal_y} = req.data[gtg_pkg::LIM_W +: 2*gtg_pkg::POS_W];

   gtg_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   logic out_v_ff;
   assign en = !out_v_ff || rsp.ready;
   assign req.ready = en;

   assign dx = XW'(goal_x) - XW'(pos_x);
   assign dy = XW'(goal_y) - XW'(pos_y);

   gtg_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE_W)) u_cordic (
      .clock, .reset, .en,
      .in_valid(req.valid), .in_x(dx), .in_y(dy),
      .in_side({req.data[gtg_pkg::LIM_W+2*gtg_pkg::POS_W +: gtg_pkg::HEAD_W],
                req.data[0 +: gtg_pkg::LIM_W]}),
      .out_valid(c_valid), .out_x(c_x), .out_acc(c_acc), .out_zero(c_zero),
      .out_side(c_side)
   );

   gtg_post #(.FRAC_BITS(FRAC_BITS)) u_post (
      .clock, .reset, .en,
      .in_valid(c_valid), .in_x(c_x), .in_acc(c_acc), .in_zero(c_zero),
      .in_heading($signed(c_side[gtg_pkg::LIM_W +: gtg_pkg::HEAD_W])),
      .in_limit(c_side[0 +: gtg_pkg::LIM_W]), .cfg,
      .out_valid(p_valid), .out_linear(lin), .out_angular(ang)
   );

   logic [gtg_pkg::LIM_W+gtg_pkg::ANG_OUT_W-1:0] out_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= p_valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         out_d_ff <= {lin, ang};
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_d_ff;
endmodule

>>> rtl/core/gtg_checker.sv
module gtg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [27:0] rsp_data,
   input logic        csr_pready
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while output full and stalled");
   a_ang_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data[14:0] != 15'h4000)
      else $error("angular rate out of range");
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
endmodule

bind go_to_goal_velocity_top gtg_checker u_gtg_checker (
   .clock(clock), .reset(reset), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
   .csr_pready(csr_pready)
);
